>>> rtl/core/assert_macros.svh
// Assertion macros shared by the checker files of this block.
// Depends on nothing; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at each rising clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |-> (post)) \
    else $error("same-cycle property failed");

// Next-cycle implication, checked at each rising clock edge outside reset.
`define ASSERT_NEXT(label, clk, rst_n, pre, post) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (pre) |=> (post)) \
    else $error("next-cycle property failed");

`endif

>>> rtl/core/wmmm_pkg.sv
// Shared types and constants for the windowed min/max/mean block.
// Depends on nothing; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps

package wmmm_pkg;

  localparam int unsigned SampleW = 32;
  localparam int unsigned FillW   = 7;
  localparam int unsigned DivCntW = 5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RDOLD,
    ST_SUBOLD,
    ST_WRITE,
    ST_SCAN,
    ST_SCANEND,
    ST_DIV,
    ST_HOLD
  } state_e;

  typedef struct packed {
    logic sample_load;
    logic rd_old;
    logic sub_old;
    logic wr_new;
    logic scan_rd;
    logic div_start;
    logic div_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic scan_last;
    logic div_last;
  } status_t;

endpackage

>>> rtl/core/wmmm_ctrl.sv
// Controller state machine for the windowed min/max/mean block.
// Depends on wmmm_pkg; drives the datapath through wmmm_pkg::cmd_t.
`timescale 1ns / 1ps

module wmmm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  wmmm_pkg::status_t status_i,
  output wmmm_pkg::cmd_t    cmd_o
);

  wmmm_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      wmmm_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.full ? wmmm_pkg::ST_RDOLD : wmmm_pkg::ST_WRITE;
        end
      end
      wmmm_pkg::ST_RDOLD:   state_d = wmmm_pkg::ST_SUBOLD;
      wmmm_pkg::ST_SUBOLD:  state_d = wmmm_pkg::ST_WRITE;
      wmmm_pkg::ST_WRITE:   state_d = wmmm_pkg::ST_SCAN;
      wmmm_pkg::ST_SCAN: begin
        if (status_i.scan_last) begin
          state_d = wmmm_pkg::ST_SCANEND;
        end
      end
      wmmm_pkg::ST_SCANEND: state_d = wmmm_pkg::ST_DIV;
      wmmm_pkg::ST_DIV: begin
        if (status_i.div_last) begin
          state_d = wmmm_pkg::ST_HOLD;
        end
      end
      wmmm_pkg::ST_HOLD: begin
        if (out_free) begin
          state_d = wmmm_pkg::ST_IDLE;
        end
      end
      default: state_d = wmmm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    unique case (state_q)
      wmmm_pkg::ST_IDLE: begin
        in_ready_o        = 1'b1;
        cmd_o.sample_load = in_valid_i;
      end
      wmmm_pkg::ST_RDOLD:   cmd_o.rd_old    = 1'b1;
      wmmm_pkg::ST_SUBOLD:  cmd_o.sub_old   = 1'b1;
      wmmm_pkg::ST_WRITE:   cmd_o.wr_new    = 1'b1;
      wmmm_pkg::ST_SCAN:    cmd_o.scan_rd   = 1'b1;
      wmmm_pkg::ST_SCANEND: cmd_o.div_start = 1'b1;
      wmmm_pkg::ST_DIV:     cmd_o.div_step  = 1'b1;
      wmmm_pkg::ST_HOLD: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= wmmm_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

>>> rtl/core/wmmm_datapath.sv
// Datapath for the windowed min/max/mean block: sample ring, running total,
// min/max scan and a restoring divider. Depends on wmmm_pkg.
`timescale 1ns / 1ps

module wmmm_datapath #(
  parameter int unsigned WINDOW = 100
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  wmmm_pkg::cmd_t                     cmd_i,
  output wmmm_pkg::status_t                  status_o,
  input  logic [wmmm_pkg::SampleW-1:0]       sample_i,
  output logic [wmmm_pkg::SampleW-1:0]       minimum_o,
  output logic [wmmm_pkg::SampleW-1:0]       maximum_o,
  output logic [wmmm_pkg::SampleW-1:0]       mean_o,
  output logic [wmmm_pkg::FillW-1:0]         fill_count_o
);

  localparam int unsigned SW = wmmm_pkg::SampleW;
  localparam int unsigned AW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CW = $clog2(WINDOW + 1);
  localparam int unsigned TW = SW + CW;
  localparam int unsigned DW = wmmm_pkg::DivCntW;

  logic [SW-1:0] mem_q [WINDOW];
  logic [SW-1:0] rdata_q;
  logic          rd_vld_q;
  logic [AW-1:0] rd_addr;
  logic          rd_en;

  logic [SW-1:0] sample_q;
  logic [AW-1:0] wp_q;
  logic [CW-1:0] cnt_q;
  logic [TW-1:0] total_q;
  logic [AW-1:0] scan_idx_q;
  logic [SW-1:0] lo_q, hi_q;

  logic [CW-1:0] rem_q;
  logic [SW-1:0] quo_q;
  logic [DW-1:0] div_cnt_q;
  logic [CW:0]   trial;
  logic          trial_ge;

  logic [CW+wmmm_pkg::FillW-1:0] cnt_ext;

  assign status_o.full      = (cnt_q == CW'(WINDOW));
  assign status_o.scan_last = (CW'(scan_idx_q) == (cnt_q - CW'(1)));
  assign status_o.div_last  = (div_cnt_q == DW'(SW - 1));

  assign rd_en   = cmd_i.rd_old || cmd_i.scan_rd;
  assign rd_addr = cmd_i.rd_old ? wp_q : scan_idx_q;

  // Sample ring; contents are meaningful only where they have been written.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_new) begin
      mem_q[wp_q] <= sample_q;
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  assign trial    = {rem_q, quo_q[SW-1]};
  assign trial_ge = (trial >= {1'b0, cnt_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      cnt_q    <= '0;
      total_q  <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      rd_vld_q <= cmd_i.scan_rd;
      if (cmd_i.sub_old) begin
        total_q <= total_q - TW'(rdata_q);
      end
      if (cmd_i.wr_new) begin
        total_q <= total_q + TW'(sample_q);
        wp_q    <= (wp_q == AW'(WINDOW - 1)) ? '0 : wp_q + AW'(1);
        if (!status_o.full) begin
          cnt_q <= cnt_q + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sample_load) begin
      sample_q   <= sample_i;
      lo_q       <= sample_i;
      hi_q       <= sample_i;
      scan_idx_q <= '0;
    end
    if (cmd_i.scan_rd) begin
      scan_idx_q <= scan_idx_q + AW'(1);
    end
    if (rd_vld_q) begin
      if (rdata_q < lo_q) begin
        lo_q <= rdata_q;
      end
      if (rdata_q > hi_q) begin
        hi_q <= rdata_q;
      end
    end
    // The quotient always fits 32 bits, so the upper total bits start as remainder.
    if (cmd_i.div_start) begin
      rem_q     <= total_q[TW-1:SW];
      quo_q     <= total_q[SW-1:0];
      div_cnt_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q     <= trial_ge ? CW'(trial - {1'b0, cnt_q}) : trial[CW-1:0];
      quo_q     <= {quo_q[SW-2:0], trial_ge};
      div_cnt_q <= div_cnt_q + DW'(1);
    end
  end

  assign cnt_ext = (CW + wmmm_pkg::FillW)'(cnt_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      minimum_o    <= lo_q;
      maximum_o    <= hi_q;
      mean_o       <= quo_q;
      fill_count_o <= cnt_ext[wmmm_pkg::FillW-1:0];
    end
  end

endmodule

>>> rtl/core/windowed_min_max_mean.sv
// Sliding-window minimum, maximum and mean. Each input transfer carries one
// unsigned 32-bit sample, which is written into a ring of WINDOW entries,
// replacing the oldest entry once the ring is full. Exactly one output
// transfer follows each input transfer, giving the minimum, the maximum and
// the floor mean of the samples now held (the new one included) and the
// number held, reported modulo 128 on the 7-bit fill_count_o. For each sample,
// a serial scan reads every held ring entry, one entry per cycle, through
// the single-ported sample memory, and a restoring divider produces the
// 32 quotient bits, one quotient bit per cycle. When the ring is full, the
// overwritten entry is first read and subtracted. The input side is ready
// again as soon as a result is loaded into the output register, even if
// that result has not yet been taken. There is no clearing pass after
// reset; ring entries are only read once written.
// Depends on wmmm_pkg, wmmm_ctrl and wmmm_datapath.
`timescale 1ns / 1ps

module windowed_min_max_mean #(
  parameter int unsigned WINDOW = 100
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [wmmm_pkg::SampleW-1:0] sample_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [wmmm_pkg::SampleW-1:0] minimum_o,
  output logic [wmmm_pkg::SampleW-1:0] maximum_o,
  output logic [wmmm_pkg::SampleW-1:0] mean_o,
  output logic [wmmm_pkg::FillW-1:0]   fill_count_o
);

  // The controller sequences each sample through its phases: an optional
  // read and subtract of the overwritten entry, the write of the new one,
  // the scan, the divide and the load of the output register.
  wmmm_pkg::cmd_t    cmd;
  wmmm_pkg::status_t status;

  wmmm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // The datapath holds the ring, the fill count, the running total and
  // the output register.
  wmmm_datapath #(
    .WINDOW(WINDOW)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .sample_i    (sample_i),
    .minimum_o   (minimum_o),
    .maximum_o   (maximum_o),
    .mean_o      (mean_o),
    .fill_count_o(fill_count_o)
  );

endmodule

>>> rtl/core/wmmm_checker.sv
// Port-level checker for the windowed min/max/mean block, bound to the top.
// Depends on wmmm_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module wmmm_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         in_valid_i,
  input logic                         in_ready_o,
  input logic                         out_valid_o,
  input logic                         out_ready_i,
  input logic [wmmm_pkg::SampleW-1:0] minimum_o,
  input logic [wmmm_pkg::SampleW-1:0] maximum_o,
  input logic [wmmm_pkg::SampleW-1:0] mean_o
);

  `ASSERT_IMPL(a_min_le_max, clk_i, rst_ni, out_valid_o, minimum_o <= maximum_o)
  `ASSERT_IMPL(a_mean_in_range, clk_i, rst_ni, out_valid_o, (minimum_o <= mean_o) && (mean_o <= maximum_o))
  `ASSERT_NEXT(a_busy_after_in, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `ASSERT_NEXT(a_out_held, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(mean_o))

endmodule

bind windowed_min_max_mean wmmm_checker u_wmmm_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_valid_i),
  .in_ready_o (in_ready_o),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .minimum_o  (minimum_o),
  .maximum_o  (maximum_o),
  .mean_o     (mean_o)
);

>>> test/windowed_min_max_mean_test.sv
// Self-checking testbench for windowed_min_max_mean: drives samples, predicts
// the window statistics and compares every output transfer against them.
// Depends on wmmm_pkg and the windowed_min_max_mean RTL.
`timescale 1ns / 1ps

module windowed_min_max_mean_test;

  // The ring depth must match the instance parameter below.
  localparam int unsigned WINDOW       = 100;
  // Percentage of cycles in which either side holds off.
  localparam int unsigned IDLE_PCT     = 15;
  // Cycles without any transfer before the run is declared hung.
  localparam int unsigned STALL_LIMIT  = 2000;
  // Quiet time after the last expected result, to catch stray transfers.
  localparam int unsigned DRAIN_CYCLES = 200;
  localparam int unsigned RANDOM_ITEMS = 1100;
  localparam int unsigned MAX_PRINTED  = 40;

  typedef logic [wmmm_pkg::SampleW-1:0] sample_t;
  typedef logic [wmmm_pkg::FillW-1:0]   fill_t;

  // One result of the block: the statistics over the filled window.
  typedef struct packed {
    sample_t lo;
    sample_t hi;
    sample_t avg;
    fill_t   fill;
  } stats_t;

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  logic    in_ready;
  sample_t sample    = '0;
  logic    out_valid;
  logic    out_ready = 1'b0;
  sample_t minimum;
  sample_t maximum;
  sample_t mean;
  fill_t   fill_count;

  windowed_min_max_mean #(
    .WINDOW(WINDOW)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .sample_i    (sample),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .minimum_o   (minimum),
    .maximum_o   (maximum),
    .mean_o      (mean),
    .fill_count_o(fill_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the window. Only the first `held` entries are ever
  // visited, which mirrors the block never reading an unwritten slot.
  sample_t     ring [WINDOW];
  int unsigned next_slot  = 0;
  int unsigned held       = 0;
  logic [63:0] window_sum = '0;
  stats_t      pending_stats [$];
  int unsigned mismatches = 0;
  int unsigned idle_run   = 0;
  // While set, neither side holds off; used for one long back-to-back stretch.
  bit          steady     = 1'b0;

  // Updates the shadow window with an accepted sample and queues the
  // statistics the block has to report for it.
  function automatic void predict_window_stats(input sample_t value);
    stats_t r;
    // Once the window is full the new sample overwrites the oldest entry,
    // so that entry leaves the running sum first.
    if (held == WINDOW) begin
      window_sum -= ring[next_slot];
    end else begin
      held++;
    end
    ring[next_slot] = value;
    window_sum += value;
    next_slot = (next_slot + 1 == WINDOW) ? 0 : next_slot + 1;
    r.lo = value;
    r.hi = value;
    for (int unsigned i = 0; i < held; i++) begin
      if (ring[i] < r.lo) r.lo = ring[i];
      if (ring[i] > r.hi) r.hi = ring[i];
    end
    // Floor mean; the divisor is at least one after every sample.
    r.avg  = sample_t'(window_sum / held);
    r.fill = fill_t'(held);
    pending_stats.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input sample_t got, input sample_t want);
    if (mismatches < MAX_PRINTED) begin
      $display("%0t ns: %s got %h, want %h", $time, what, got, want);
    end
    mismatches++;
  endtask

  // Sends one sample. It is entered and left at a falling edge. Valid is
  // only lowered when a gap is taken, so back-to-back transfers keep valid
  // high without a second assignment in the same time step.
  task automatic push_sample(input sample_t value);
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    sample   <= value;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_window_stats(value);
    @(negedge clk);
  endtask

  // Mixes fully random values with values close to the edges and the middle of the range
  // and with single-bit and single-zero patterns, so that ties and extremes come up often.
  function automatic sample_t random_sample();
    int unsigned pick;
    pick = $urandom_range(9);
    case (pick)
      4: begin
        return sample_t'($urandom_range(15));
      end
      5: begin
        return '1 - sample_t'($urandom_range(15));
      end
      6: begin
        return $urandom_range(1) ? '1 : '0;
      end
      7: begin
        return sample_t'(1) << $urandom_range(31);
      end
      8: begin
        return ~(sample_t'(1) << $urandom_range(31));
      end
      9: begin
        return 32'h8000_0000 + sample_t'($urandom_range(15)) - 32'd8;
      end
      default: begin
        return sample_t'($urandom());
      end
    endcase
  endfunction

  // Range limits, sign-bit neighbors and alternating patterns while the
  // window is still filling, so fill_count and the mean divisor are small.
  task automatic test_directed_extremes();
    sample_t corner [20] = '{
      32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0000_0001,
      32'hFFFF_FFFE, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
      32'hAAAA_AAAA, 32'h5555_5555, 32'h0000_FFFF, 32'hFFFF_0000,
      32'h0000_0001, 32'hFFFF_FFFF, 32'h1234_5678, 32'h0000_0000,
      32'h7FFF_FFFF, 32'hEDCB_A987, 32'h0000_0002, 32'hFFFF_FFFD
    };
    foreach (corner[i]) push_sample(corner[i]);
  endtask

  // A window filled entirely with the largest value drives the running sum
  // to its maximum and the mean to all ones; it is then flushed with zeros.
  // Both passes wrap the ring. This is the stretch with no idling at all.
  task automatic test_saturated_window();
    steady = 1'b1;
    repeat (WINDOW + 10) push_sample('1);
    repeat (WINDOW + 10) push_sample('0);
    steady = 1'b0;
  endtask

  // A single spike or dip followed by a full window of mid-range values:
  // the extreme must drop out of the statistics exactly when its slot is
  // overwritten.
  task automatic test_evicted_extremes();
    for (int r = 0; r < 4; r++) begin
      if (r % 2 == 0) begin
        push_sample('1 - sample_t'($urandom_range(3)));
      end else begin
        push_sample(sample_t'($urandom_range(3)));
      end
      repeat (WINDOW) push_sample(sample_t'($urandom_range(32'hBFFF_FFFF, 32'h4000_0000)));
    end
  endtask

  task automatic test_random_mix();
    repeat (RANDOM_ITEMS) push_sample(random_sample());
  endtask

  // The receiver holds off at random outside the steady stretch.
  always @(negedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // Each output transfer is compared with the oldest prediction.
  always @(posedge clk) begin : check_result
    stats_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_stats.size() == 0) begin
        report_mismatch("unexpected result, minimum", minimum, '0);
      end else begin
        want = pending_stats.pop_front();
        if (minimum !== want.lo) report_mismatch("minimum", minimum, want.lo);
        if (maximum !== want.hi) report_mismatch("maximum", maximum, want.hi);
        if (mean !== want.avg) report_mismatch("mean", mean, want.avg);
        if (fill_count !== want.fill) begin
          report_mismatch("fill_count", sample_t'(fill_count), sample_t'(want.fill));
        end
      end
    end
  end

  // Ends a hung run: too many cycles in which neither channel transfers.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_run <= 0;
      end else if (idle_run >= STALL_LIMIT) begin
        $display("windowed_min_max_mean: mismatch");
        $finish;
      end else begin
        idle_run <= idle_run + 1;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_extremes();
    test_saturated_window();
    test_evicted_extremes();
    test_random_mix();

    in_valid <= 1'b0;
    while (pending_stats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("windowed_min_max_mean: match");
    end else begin
      $display("windowed_min_max_mean: mismatch");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl/core
rtl/core/wmmm_pkg.sv
rtl/core/wmmm_ctrl.sv
rtl/core/wmmm_datapath.sv
rtl/core/windowed_min_max_mean.sv
rtl/core/wmmm_checker.sv
test/windowed_min_max_mean_test.sv
